// File: hdl/ftcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ftcr_pkg;

   // Widths of the data fields.
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 7;
   localparam int STORE_N = 7;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CODE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LIMIT = 2'd2;

   // Configuration reset values.
   localparam logic [BYTE_W-1:0]  START_CODE_RST  = 8'h23;
   localparam logic [BYTE_W-1:0]  END_CODE_RST    = 8'h00;
   localparam logic [COUNT_W-1:0] FRAME_LIMIT_RST = 7'd100;

   // Selector characters at frame position one.
   localparam logic [BYTE_W-1:0] SEL_CURRENT = 8'h41;
   localparam logic [BYTE_W-1:0] SEL_RAISE   = 8'h42;
   localparam logic [BYTE_W-1:0] SEL_LOWER   = 8'h43;

   // Target codes.
   localparam logic [1:0] TGT_NONE    = 2'd0;
   localparam logic [1:0] TGT_CURRENT = 2'd1;
   localparam logic [1:0] TGT_RAISE   = 2'd2;
   localparam logic [1:0] TGT_LOWER   = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   // Frame positions one to seven, element 0 holds position one.
   typedef logic [STORE_N-1:0][BYTE_W-1:0] store_type;

   // Per-byte outcome of the frame tracker.
   typedef struct packed {
      logic               complete;
      logic               dropped;
      logic [COUNT_W-1:0] count;
   } step_type;

   // Two ASCII digits to a value modulo 256: 10*(hi-0x30)+(lo-0x30)
   // equals 10*hi + lo - 528, and 528 is 16 modulo 256.
   function automatic logic [BYTE_W-1:0] two_digits(input logic [BYTE_W-1:0] hi,
                                                    input logic [BYTE_W-1:0] lo);
      two_digits = {hi[4:0], 3'b000} + {hi[6:0], 1'b0} + lo - 8'd16;
   endfunction

endpackage

`default_nettype wire

// File: hdl/ftcr_frame_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

module ftcr_frame_tracker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step_en,
   input  wire logic [ftcr_pkg::BYTE_W-1:0]   rx_byte,
   input  wire logic [ftcr_pkg::BYTE_W-1:0]   start_code,
   input  wire logic [ftcr_pkg::BYTE_W-1:0]   end_code,
   input  wire logic [ftcr_pkg::COUNT_W-1:0]  frame_limit,
   output ftcr_pkg::step_type                 step,
   output ftcr_pkg::store_type                store_now
);

   logic                         collecting_ff, collecting_in;
   logic [ftcr_pkg::COUNT_W-1:0] count_ff, count_in;
   ftcr_pkg::store_type          store_ff, store_in;

   logic [ftcr_pkg::COUNT_W-1:0] threshold;
   logic                         is_start;
   logic                         is_end;
   logic                         at_threshold;
   logic                         put_en;
   logic [2:0]                   put_pos;
   logic [ftcr_pkg::COUNT_W-1:0] count_inc;

   // Decisions for the byte in hand.
   always_comb begin
      threshold    = frame_limit - 7'd1;
      is_start     = (rx_byte == start_code);
      is_end       = (rx_byte == end_code);
      at_threshold = (count_ff == threshold);
      // An end code is always taken; a data byte only below the threshold.
      put_en       = collecting_ff &&
                     (is_end || (!is_start && (count_ff < threshold)));
      put_pos      = count_ff[2:0];
      count_inc    = (count_ff == ftcr_pkg::COUNT_MAX) ? count_ff : count_ff + 7'd1;
   end

   // Next state, store contents and per-byte flags.
   always_comb begin
      store_in = store_ff;
      if (put_en && (count_ff < 7'd8) && (count_ff != 7'd0)) begin
         store_in[put_pos - 3'd1] = rx_byte;
      end

      if (!collecting_ff) begin
         collecting_in = is_start;
         count_in      = is_start ? 7'd1 : count_ff;
      end else begin
         if (is_start) begin
            collecting_in = 1'b1;
         end else begin
            collecting_in = !is_end && !at_threshold;
         end
         if (is_start) begin
            count_in = 7'd1;
         end else if (put_en) begin
            count_in = count_inc;
         end else begin
            count_in = count_ff;
         end
      end

      step.complete = collecting_ff && is_end;
      step.dropped  = collecting_ff && !is_end && !is_start && at_threshold;
      step.count    = count_in;
      store_now     = store_in;
   end

   // Tracker state advances once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         count_ff      <= '0;
         store_ff      <= '0;
      end else if (step_en) begin
         collecting_ff <= collecting_in;
         count_ff      <= count_in;
         store_ff      <= store_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/ftcr_time_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module ftcr_time_decode (
   input  wire logic                         complete,
   input  wire ftcr_pkg::store_type          store,
   output logic [1:0]                        target,
   output logic [ftcr_pkg::BYTE_W-1:0]       hours,
   output logic [ftcr_pkg::BYTE_W-1:0]       minutes,
   output logic [ftcr_pkg::BYTE_W-1:0]       seconds
);

   logic [1:0] sel_target;

   // Map the selector character to a target.
   always_comb begin
      case (store[0])
         ftcr_pkg::SEL_CURRENT: sel_target = ftcr_pkg::TGT_CURRENT;
         ftcr_pkg::SEL_RAISE:   sel_target = ftcr_pkg::TGT_RAISE;
         ftcr_pkg::SEL_LOWER:   sel_target = ftcr_pkg::TGT_LOWER;
         default:               sel_target = ftcr_pkg::TGT_NONE;
      endcase
   end

   // Digits decode only for a closed frame with a known selector.
   always_comb begin
      target  = complete ? sel_target : ftcr_pkg::TGT_NONE;
      hours   = '0;
      minutes = '0;
      seconds = '0;
      if (target != ftcr_pkg::TGT_NONE) begin
         hours   = ftcr_pkg::two_digits(store[1], store[2]);
         minutes = ftcr_pkg::two_digits(store[3], store[4]);
         seconds = ftcr_pkg::two_digits(store[5], store[6]);
      end
   end

endmodule

`default_nettype wire

// File: hdl/framed_time_command_receiver_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Receiver for delimited time-setting frames arriving as serial bytes.
// Each byte enters on the req_ stream; each byte yields exactly one
// transaction on the rsp_ stream carrying the frame status after that byte.
// A frame opens with start_code, closes with end_code, and position one
// selects the current, raise or lower time; positions two to seven hold the
// ASCII hours, minutes and seconds, decoded when the frame closes.
// The csr_ port writes start_code, end_code and frame_limit; it is always
// ready and should be used only while the block is idle.
// A byte accepted on req_ is registered in the input register, and its result
// from the frame tracker and time decoder is registered in the result register.
// Throughput: one byte per cycle while the rsp_ side does not stall, set by the
// frame tracker between the input register and the result register.
// When the rsp_ side stalls, the result register holds its transaction; the
// input register takes one more byte only if it is empty, and req_tready is
// then low.
// Reset clears both stages, returns the tracker to hunting with a zero count
// and a zeroed frame store, and restores the configuration defaults.
module framed_time_command_receiver_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input bytes. tdata: rx_byte[7:0].
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   // Results. tdata: hours[7:0], minutes[15:8], seconds[23:16],
   // count_now[30:24], zero [31]. tuser: frame_dropped[0], target[2:1].
   // tlast: frame_complete.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,
   output logic [2:0]       rsp_tuser,
   output logic             rsp_tlast,
   // Configuration writes.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   logic [ftcr_pkg::BYTE_W-1:0]  start_code_ff;
   logic [ftcr_pkg::BYTE_W-1:0]  end_code_ff;
   logic [ftcr_pkg::COUNT_W-1:0] frame_limit_ff;

   logic                         in_valid_ff;
   logic [ftcr_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                         out_valid_ff;
   logic [31:0]                  out_data_ff, out_data_in;
   logic [2:0]                   out_user_ff, out_user_in;
   logic                         out_last_ff, out_last_in;

   logic                         advance;
   ftcr_pkg::step_type           step;
   ftcr_pkg::store_type          store_now;
   logic [1:0]                   target;
   logic [ftcr_pkg::BYTE_W-1:0]  hours;
   logic [ftcr_pkg::BYTE_W-1:0]  minutes;
   logic [ftcr_pkg::BYTE_W-1:0]  seconds;

   // Handshake: the input stage moves on when the result register is free or is being taken.
   always_comb begin
      advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready = !in_valid_ff || advance;
      csr_ready  = 1'b1;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff  <= ftcr_pkg::START_CODE_RST;
         end_code_ff    <= ftcr_pkg::END_CODE_RST;
         frame_limit_ff <= ftcr_pkg::FRAME_LIMIT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            ftcr_pkg::CSR_START_CODE:  start_code_ff  <= csr_data;
            ftcr_pkg::CSR_END_CODE:    end_code_ff    <= csr_data;
            ftcr_pkg::CSR_FRAME_LIMIT: frame_limit_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   ftcr_frame_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .rx_byte     (in_byte_ff),
      .start_code  (start_code_ff),
      .end_code    (end_code_ff),
      .frame_limit (frame_limit_ff),
      .step        (step),
      .store_now   (store_now)
   );

   ftcr_time_decode u_decode (
      .complete (step.complete),
      .store    (store_now),
      .target   (target),
      .hours    (hours),
      .minutes  (minutes),
      .seconds  (seconds)
   );

   // Pack the result transaction.
   always_comb begin
      out_data_in = {1'b0, step.count, seconds, minutes, hours};
      out_user_in = {target, step.dropped};
      out_last_in = step.complete;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
         out_last_ff <= out_last_in;
      end
   end

   always_comb begin
      rsp_tvalid = out_valid_ff;
      rsp_tdata  = out_data_ff;
      rsp_tuser  = out_user_ff;
      rsp_tlast  = out_last_ff;
   end

endmodule

`default_nettype wire
